@@ design/sat_pkg.sv @@
`timescale 1ns / 1ps

package sat_pkg;

   // fixed field and register widths
   localparam int CFG_RATE_BITS  = 4;
   localparam int SCALE_BITS     = 16;
   localparam int DIVIDE_BITS    = 3;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;

   // defaults for the top level parameters
   localparam int COUNTER_BITS_DEF = 16;
   localparam int RATE_BITS_DEF    = 4;

   // register reset values
   localparam logic [CFG_RATE_BITS-1:0] RATE_MIN_RST       = 4'd1;
   localparam logic [CFG_RATE_BITS-1:0] RATE_MAX_RST       = 4'd8;
   localparam logic [SCALE_BITS-1:0]    PERIOD_SCALE_RST   = 16'd31250;
   localparam logic [DIVIDE_BITS-1:0]   FIRE_DIVIDE_RST    = 3'd5;
   localparam logic [DIVIDE_BITS-1:0]   SAMPLE_DIVIDE_RST  = 3'd5;
   localparam logic [SCALE_BITS-1:0]    INITIAL_RELOAD_RST = 16'd3036;

   // register index, taken from paddr word address
   typedef enum logic [2:0] {
      REG_RATE_MIN       = 3'd0,
      REG_RATE_MAX       = 3'd1,
      REG_PERIOD_SCALE   = 3'd2,
      REG_FIRE_DIVIDE    = 3'd3,
      REG_SAMPLE_DIVIDE  = 3'd4,
      REG_INITIAL_RELOAD = 3'd5
   } sat_reg_type;

   // serial divider states
   typedef enum logic [1:0] {
      DIV_IDLE = 2'b01,
      DIV_RUN  = 2'b10
   } sat_div_state_type;

   typedef struct packed {
      logic start;
   } sat_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sat_div_stat_type;

endpackage

@@ design/sat_divider.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module sat_divider import sat_pkg::*; #(
   parameter int NUM_BITS = SCALE_BITS + 1,
   parameter int DEN_BITS = RATE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  sat_div_ctrl_type    ctrl,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output sat_div_stat_type    stat,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

   sat_div_state_type   state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS:0]   rem_shift;
   logic [DEN_BITS:0]   rem_diff;
   logic                take;
   logic                last;

   // shared subtract and compare step
   assign rem_shift = {rem_ff, num_ff[NUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign take      = (rem_shift >= {1'b0, den_ff});
   assign last      = (cnt_ff == CNT_BITS'(NUM_BITS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (ctrl.start) begin
               state_in = DIV_RUN;
               cnt_in   = '0;
               num_in   = numer;
               den_in   = denom;
               rem_in   = '0;
            end
         end
         DIV_RUN: begin
            num_in = {num_ff[NUM_BITS-2:0], take};
            rem_in = take ? rem_diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   // quotient is valid on the edge where done is high
   assign stat.busy = (state_ff == DIV_RUN);
   assign stat.done = (state_ff == DIV_RUN) && last;
   assign quotient  = num_in;

endmodule

@@ design/solenoid_alternator_timer_top.sv @@
`timescale 1ns / 1ps

// results: a taken request beat is registered in the output slot, or in the skid
//   slot while the output slot is held; requests: one beat per cycle while the skid
//   slot is empty; a stepping beat also starts the serial divider, which holds off
//   requests while it runs, whatever COUNTER_BITS is (one quotient bit per cycle)
// reset: synchronous, active high; registers and state take their documented
//   reset values at once, no clearing pass
module solenoid_alternator_timer_top import sat_pkg::*; #(
   parameter int COUNTER_BITS = COUNTER_BITS_DEF,
   parameter int RATE_BITS    = RATE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_timer_tick,
   input  logic                     req_sample_strobe,
   input  logic                     req_up_level,
   input  logic                     req_down_level,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_power_relay,
   output logic                     rsp_control_relay,
   output logic [CFG_RATE_BITS-1:0] rsp_current_rate,
   output logic                     rsp_fired,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CMP_BITS = (RATE_BITS > CFG_RATE_BITS) ? RATE_BITS : CFG_RATE_BITS;
   localparam int NUM_BITS = SCALE_BITS + 1;
   localparam logic [RATE_BITS-1:0] RATE_TOP = {RATE_BITS{1'b1}};
   localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1);

   typedef struct packed {
      logic                     power;
      logic                     control;
      logic [CFG_RATE_BITS-1:0] rate;
      logic                     fired;
   } rsp_type;

   // configuration registers
   logic [CFG_RATE_BITS-1:0] rate_min_ff, rate_min_in;
   logic [CFG_RATE_BITS-1:0] rate_max_ff, rate_max_in;
   logic [SCALE_BITS-1:0]    scale_ff, scale_in;
   logic [DIVIDE_BITS-1:0]   fire_div_ff, fire_div_in;
   logic [DIVIDE_BITS-1:0]   sample_div_ff, sample_div_in;
   logic [SCALE_BITS-1:0]    init_reload_ff, init_reload_in;

   // block state
   logic [COUNTER_BITS-1:0]  pcount_ff, pcount_in;
   logic [COUNTER_BITS-1:0]  reload_ff, reload_in;
   logic [DIVIDE_BITS-1:0]   ocount_ff, ocount_in, ocount_next;
   logic [DIVIDE_BITS-1:0]   scount_ff, scount_in, scount_next;
   logic                     last_up_ff, last_up_in;
   logic                     last_dn_ff, last_dn_in;
   logic [RATE_BITS-1:0]     rate_ff, rate_in, rate_mid;
   logic                     stage_ff, stage_in;
   logic                     power_ff, power_in;
   logic                     control_ff, control_in;
   logic                     fire_now;
   logic                     up_step;
   logic                     dn_step;

   // result slot and skid slot
   rsp_type                  out_ff, out_in;
   rsp_type                  skid_ff, skid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   rsp_type                  result;

   logic                     req_accept;
   logic                     rsp_drain;
   logic                     csr_write;
   logic [2:0]               csr_index;

   sat_div_ctrl_type         div_ctrl;
   sat_div_stat_type         div_stat;
   logic [NUM_BITS-1:0]      div_numer;
   logic [NUM_BITS-1:0]      div_quot;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   assign req_ready  = !div_stat.busy && !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_drain  = out_valid_ff && rsp_ready;

   // register writes
   always_comb begin
      rate_min_in    = rate_min_ff;
      rate_max_in    = rate_max_ff;
      scale_in       = scale_ff;
      fire_div_in    = fire_div_ff;
      sample_div_in  = sample_div_ff;
      init_reload_in = init_reload_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_RATE_MIN:       rate_min_in    = csr_pwdata[CFG_RATE_BITS-1:0];
            REG_RATE_MAX:       rate_max_in    = csr_pwdata[CFG_RATE_BITS-1:0];
            REG_PERIOD_SCALE:   scale_in       = csr_pwdata[SCALE_BITS-1:0];
            REG_FIRE_DIVIDE:    fire_div_in    = csr_pwdata[DIVIDE_BITS-1:0];
            REG_SAMPLE_DIVIDE:  sample_div_in  = csr_pwdata[DIVIDE_BITS-1:0];
            REG_INITIAL_RELOAD: init_reload_in = csr_pwdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         REG_RATE_MIN:       csr_prdata = CSR_DATA_BITS'(rate_min_ff);
         REG_RATE_MAX:       csr_prdata = CSR_DATA_BITS'(rate_max_ff);
         REG_PERIOD_SCALE:   csr_prdata = CSR_DATA_BITS'(scale_ff);
         REG_FIRE_DIVIDE:    csr_prdata = CSR_DATA_BITS'(fire_div_ff);
         REG_SAMPLE_DIVIDE:  csr_prdata = CSR_DATA_BITS'(sample_div_ff);
         REG_INITIAL_RELOAD: csr_prdata = CSR_DATA_BITS'(init_reload_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // tick, overflow and relay alternation
   always_comb begin
      pcount_in   = pcount_ff;
      ocount_in   = ocount_ff;
      stage_in    = stage_ff;
      power_in    = power_ff;
      control_in  = control_ff;
      fire_now    = 1'b0;
      ocount_next = ocount_ff + 1'b1;
      if (req_accept && req_timer_tick) begin
         if (pcount_ff == {COUNTER_BITS{1'b1}}) begin
            pcount_in = reload_ff;
            ocount_in = ocount_next;
            if (ocount_next == fire_div_ff) begin
               ocount_in = '0;
               fire_now  = 1'b1;
               stage_in  = !stage_ff;
               if (!stage_ff) begin
                  control_in = !control_ff;
               end else begin
                  power_in = !power_ff;
               end
            end
         end else begin
            pcount_in = pcount_ff + 1'b1;
         end
      end
      // writing the initial reload restarts the period
      if (csr_write && csr_index == REG_INITIAL_RELOAD) begin
         pcount_in = COUNTER_BITS'(csr_pwdata[SCALE_BITS-1:0]);
      end
   end

   // button evaluation, up before down
   always_comb begin
      scount_in   = scount_ff;
      last_up_in  = last_up_ff;
      last_dn_in  = last_dn_ff;
      rate_in     = rate_ff;
      rate_mid    = rate_ff;
      up_step     = 1'b0;
      dn_step     = 1'b0;
      scount_next = scount_ff + 1'b1;
      if (req_accept && req_sample_strobe) begin
         scount_in = scount_next;
         if (scount_next == sample_div_ff) begin
            scount_in = '0;
            up_step = !last_up_ff && !req_up_level && (rate_ff != RATE_TOP) &&
                      (CMP_BITS'(rate_ff) < CMP_BITS'(rate_max_ff));
            rate_mid = up_step ? rate_ff + 1'b1 : rate_ff;
            dn_step = !last_dn_ff && !req_down_level && (rate_mid > RATE_ONE) &&
                      (CMP_BITS'(rate_mid) > CMP_BITS'(rate_min_ff));
            rate_in    = dn_step ? rate_mid - 1'b1 : rate_mid;
            last_up_in = req_up_level;
            last_dn_in = req_down_level;
         end
      end
   end

   // a rate step starts ceil(scale / rate) on the serial divider
   assign div_ctrl.start = up_step || dn_step;
   assign div_numer = NUM_BITS'(scale_ff) + NUM_BITS'(rate_in) - NUM_BITS'(1);

   sat_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (RATE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .numer    (div_numer),
      .denom    (rate_in),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // reload is the counter span minus the period, or the written initial reload
   always_comb begin
      reload_in = reload_ff;
      if (csr_write && csr_index == REG_INITIAL_RELOAD) begin
         reload_in = COUNTER_BITS'(csr_pwdata[SCALE_BITS-1:0]);
      end else if (div_stat.done) begin
         reload_in = COUNTER_BITS'(0) - COUNTER_BITS'(div_quot);
      end
   end

   // result beat, with a skid slot behind the output register
   always_comb begin
      result.power   = power_in;
      result.control = control_in;
      result.rate    = CFG_RATE_BITS'(rate_in);
      result.fired   = fire_now;
      out_in         = out_ff;
      skid_in        = skid_ff;
      out_valid_in   = out_valid_ff;
      skid_valid_in  = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_drain) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_min_ff    <= RATE_MIN_RST;
         rate_max_ff    <= RATE_MAX_RST;
         scale_ff       <= PERIOD_SCALE_RST;
         fire_div_ff    <= FIRE_DIVIDE_RST;
         sample_div_ff  <= SAMPLE_DIVIDE_RST;
         init_reload_ff <= INITIAL_RELOAD_RST;
         pcount_ff      <= COUNTER_BITS'(INITIAL_RELOAD_RST);
         reload_ff      <= COUNTER_BITS'(INITIAL_RELOAD_RST);
         ocount_ff      <= '0;
         scount_ff      <= '0;
         last_up_ff     <= 1'b1;
         last_dn_ff     <= 1'b1;
         rate_ff        <= RATE_ONE;
         stage_ff       <= 1'b0;
         power_ff       <= 1'b1;
         control_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         rate_min_ff    <= rate_min_in;
         rate_max_ff    <= rate_max_in;
         scale_ff       <= scale_in;
         fire_div_ff    <= fire_div_in;
         sample_div_ff  <= sample_div_in;
         init_reload_ff <= init_reload_in;
         pcount_ff      <= pcount_in;
         reload_ff      <= reload_in;
         ocount_ff      <= ocount_in;
         scount_ff      <= scount_in;
         last_up_ff     <= last_up_in;
         last_dn_ff     <= last_dn_in;
         rate_ff        <= rate_in;
         stage_ff       <= stage_in;
         power_ff       <= power_in;
         control_ff     <= control_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_power_relay   = out_ff.power;
   assign rsp_control_relay = out_ff.control;
   assign rsp_current_rate  = out_ff.rate;
   assign rsp_fired         = out_ff.fired;

   // no request beat while the divider runs
   assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_ready)
      else $error("request taken while divider busy");

   // every request beat leaves a result beat waiting
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("request beat without result beat");

   // a firing flips exactly one relay
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && fire_now) |=>
         ((power_ff != $past(power_ff)) != (control_ff != $past(control_ff))))
      else $error("firing did not flip one relay");

   // rate never reaches zero
   assert property (@(posedge clock) disable iff (reset)
      rate_ff != '0)
      else $error("rate dropped to zero");

endmodule

@@ dv/tb_solenoid_alternator_timer_top.sv @@
`timescale 1ns / 1ps

module tb_solenoid_alternator_timer_top;
   import sat_pkg::*;

   localparam int CNT_BITS = COUNTER_BITS_DEF;
   localparam longint unsigned CNT_SPAN = 64'd1 << CNT_BITS;
   localparam int RATE_TOP = (1 << RATE_BITS_DEF) - 1;
   // the rate divider runs on after a stepping beat
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RAND_PHASES = 6;
   localparam int BEATS_PER_PHASE = 209;
   localparam int DIR_ROWS = 24;
   localparam int GAP_PCT = 38;

   typedef struct packed {
      logic tick;
      logic strobe;
      logic up_n;
      logic down_n;
   } button_beat_t;

   typedef struct packed {
      logic                     power;
      logic                     control;
      logic [CFG_RATE_BITS-1:0] rate;
      logic                     fired;
   } relay_state_t;

   typedef struct packed {
      logic         on;
      relay_state_t val;
   } relay_pin_t;

   typedef struct packed {
      logic [1:0]   phase;
      button_beat_t beat;
      logic         pinned;
      relay_state_t want;
   } timer_row_t;

   // directed rows: phase, {tick, strobe, up_n, down_n}, pinned, {power, control, rate, fired}
   localparam timer_row_t TIMER_ROWS [DIR_ROWS] = '{
      // reset settings: nothing can fire or step yet
      {2'd0, 4'b0011, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0},
      {2'd0, 4'b1011, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0},
      {2'd0, 4'b1000, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0},
      // short period, every overflow fires, every strobe evaluates
      {2'd1, 4'b1101, 1'b0, 7'd0},
      {2'd1, 4'b1101, 1'b0, 7'd0},
      {2'd1, 4'b1100, 1'b0, 7'd0},
      {2'd1, 4'b0100, 1'b0, 7'd0},
      {2'd1, 4'b1110, 1'b0, 7'd0},
      {2'd1, 4'b1011, 1'b0, 7'd0},
      {2'd1, 4'b1011, 1'b0, 7'd0},
      // zero fire divider, zero scale, counter stuck at top
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b1011, 1'b0, 7'd0},
      {2'd2, 4'b0110, 1'b0, 7'd0},
      {2'd2, 4'b0110, 1'b0, 7'd0},
      {2'd2, 4'b0101, 1'b0, 7'd0},
      {2'd2, 4'b0101, 1'b0, 7'd0},
      {2'd2, 4'b0101, 1'b0, 7'd0},
      {2'd2, 4'b1100, 1'b0, 7'd0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_timer_tick = 1'b0;
   logic                     req_sample_strobe = 1'b0;
   logic                     req_up_level = 1'b1;
   logic                     req_down_level = 1'b1;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_power_relay;
   logic                     rsp_control_relay;
   logic [CFG_RATE_BITS-1:0] rsp_current_rate;
   logic                     rsp_fired;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // register copies
   logic [CFG_RATE_BITS-1:0] cfg_rate_lo = RATE_MIN_RST;
   logic [CFG_RATE_BITS-1:0] cfg_rate_hi = RATE_MAX_RST;
   logic [SCALE_BITS-1:0]    cfg_scale = PERIOD_SCALE_RST;
   logic [DIVIDE_BITS-1:0]   cfg_fire_div = FIRE_DIVIDE_RST;
   logic [DIVIDE_BITS-1:0]   cfg_smp_div = SAMPLE_DIVIDE_RST;
   logic [SCALE_BITS-1:0]    cfg_init = INITIAL_RELOAD_RST;

   // timer state as predicted
   logic [CNT_BITS-1:0]      tmr_count = CNT_BITS'(INITIAL_RELOAD_RST);
   logic [CNT_BITS-1:0]      tmr_reload = CNT_BITS'(INITIAL_RELOAD_RST);
   logic [2:0]               ovf_count = '0;
   logic [2:0]               smp_count = '0;
   logic                     up_prev = 1'b1;
   logic                     dn_prev = 1'b1;
   logic [CFG_RATE_BITS-1:0] sel_rate = 4'd1;
   logic                     fire_stage = 1'b0;
   logic                     power_lvl = 1'b1;
   logic                     control_lvl = 1'b0;

   relay_state_t pending_relays[$];
   relay_pin_t   pin_q[$];

   logic gaps_on = 1'b1;
   int   err_count = 0;
   int   cycle_count = 0;
   int   beats_taken = 0;
   int   results_seen = 0;
   int   fires_seen = 0;
   int   rate_steps = 0;
   int   settings_done = 0;

   solenoid_alternator_timer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timer_tick    (req_timer_tick),
      .req_sample_strobe (req_sample_strobe),
      .req_up_level      (req_up_level),
      .req_down_level    (req_down_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_power_relay   (rsp_power_relay),
      .rsp_control_relay (rsp_control_relay),
      .rsp_current_rate  (rsp_current_rate),
      .rsp_fired         (rsp_fired),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_relays.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= 10)
         $display("ERROR: %s", msg);
   endtask

   // one beat through the timer: tick first, then the button evaluation
   function automatic relay_state_t advance_timer(input button_beat_t b);
      relay_state_t r;
      logic stepped;
      int unsigned span;
      r.fired = 1'b0;
      stepped = 1'b0;
      if (b.tick) begin
         if (tmr_count == '1) begin
            tmr_count = tmr_reload;
            ovf_count = ovf_count + 3'd1;
            if (ovf_count == cfg_fire_div) begin
               ovf_count = '0;
               r.fired = 1'b1;
               if (!fire_stage)
                  control_lvl = ~control_lvl;
               else
                  power_lvl = ~power_lvl;
               fire_stage = ~fire_stage;
            end
         end else begin
            tmr_count = tmr_count + 1'b1;
         end
      end
      if (b.strobe) begin
         smp_count = smp_count + 3'd1;
         if (smp_count == cfg_smp_div) begin
            smp_count = '0;
            // up wins first, down then sees the raised rate
            if (!up_prev && !b.up_n && sel_rate < cfg_rate_hi && sel_rate < RATE_TOP) begin
               sel_rate = sel_rate + 1'b1;
               stepped = 1'b1;
            end
            if (!dn_prev && !b.down_n && sel_rate > cfg_rate_lo && sel_rate > 1) begin
               sel_rate = sel_rate - 1'b1;
               stepped = 1'b1;
            end
            up_prev = b.up_n;
            dn_prev = b.down_n;
            if (stepped) begin
               span = (32'(cfg_scale) + 32'(sel_rate) - 1) / 32'(sel_rate);
               tmr_reload = CNT_BITS'(CNT_SPAN - span);
               rate_steps++;
            end
         end
      end
      r.power = power_lvl;
      r.control = control_lvl;
      r.rate = sel_rate;
      return r;
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= gaps_on ? ($urandom_range(0, 99) >= GAP_PCT) : 1'b1;
   end

   // beat monitor and result check
   always @(posedge clock) begin
      button_beat_t beat;
      relay_state_t want;
      relay_state_t got;
      relay_pin_t   pin;
      if (!reset) begin
         if (req_valid && req_ready) begin
            beat = {req_timer_tick, req_sample_strobe, req_up_level, req_down_level};
            want = advance_timer(beat);
            if (pin_q.size() != 0) begin
               pin = pin_q.pop_front();
               if (pin.on)
                  want = pin.val;
            end
            pending_relays.push_back(want);
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_power_relay, rsp_control_relay, rsp_current_rate, rsp_fired};
            results_seen++;
            if (got.fired === 1'b1)
               fires_seen++;
            if (pending_relays.size() == 0) begin
               note_error($sformatf("result beat %0d arrived with nothing pending", results_seen));
            end else begin
               want = pending_relays.pop_front();
               if (got.power !== want.power || got.control !== want.control ||
                   got.rate !== want.rate || got.fired !== want.fired)
                  note_error($sformatf(
                     "beat %0d exp/got: power %b/%b control %b/%b rate %0d/%0d fired %b/%b",
                     results_seen, want.power, got.power, want.control, got.control,
                     want.rate, got.rate, want.fired, got.fired));
            end
         end
      end
   end

   // one request beat, with random gaps ahead of it
   task automatic send_beat(input button_beat_t b);
      while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timer_tick <= b.tick;
      req_sample_strobe <= b.strobe;
      req_up_level <= b.up_n;
      req_down_level <= b.down_n;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold requests until every pending result is back
   task automatic drain_relays(input bit settle);
      req_valid <= 1'b0;
      // let the last accepted beat reach the pending queue
      @(posedge clock);
      while (pending_relays.size() != 0)
         @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register, update the copy, then read it back
   task automatic csr_write_check(input sat_reg_type idx, input logic [CSR_DATA_BITS-1:0] val);
      logic [CSR_DATA_BITS-1:0] want;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_RATE_MIN:      cfg_rate_lo = val[CFG_RATE_BITS-1:0];
         REG_RATE_MAX:      cfg_rate_hi = val[CFG_RATE_BITS-1:0];
         REG_PERIOD_SCALE:  cfg_scale = val[SCALE_BITS-1:0];
         REG_FIRE_DIVIDE:   cfg_fire_div = val[DIVIDE_BITS-1:0];
         REG_SAMPLE_DIVIDE: cfg_smp_div = val[DIVIDE_BITS-1:0];
         REG_INITIAL_RELOAD: begin
            // also restarts the period counter
            cfg_init = val[SCALE_BITS-1:0];
            tmr_count = CNT_BITS'(cfg_init);
            tmr_reload = CNT_BITS'(cfg_init);
         end
         default: ;
      endcase
      case (idx)
         REG_RATE_MIN:      want = CSR_DATA_BITS'(cfg_rate_lo);
         REG_RATE_MAX:      want = CSR_DATA_BITS'(cfg_rate_hi);
         REG_PERIOD_SCALE:  want = CSR_DATA_BITS'(cfg_scale);
         REG_FIRE_DIVIDE:   want = CSR_DATA_BITS'(cfg_fire_div);
         REG_SAMPLE_DIVIDE: want = CSR_DATA_BITS'(cfg_smp_div);
         default:           want = CSR_DATA_BITS'(cfg_init);
      endcase
      // read back through a fresh setup phase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         note_error($sformatf("register %s read back %0h, expected %0h", idx.name(),
                              csr_prdata, want));
   endtask

   task automatic program_timer(input logic [3:0] rmin, input logic [3:0] rmax,
                                input logic [15:0] scale, input logic [2:0] fire,
                                input logic [2:0] smp, input logic [15:0] init);
      csr_write_check(REG_RATE_MIN, CSR_DATA_BITS'(rmin));
      csr_write_check(REG_RATE_MAX, CSR_DATA_BITS'(rmax));
      csr_write_check(REG_PERIOD_SCALE, CSR_DATA_BITS'(scale));
      csr_write_check(REG_FIRE_DIVIDE, CSR_DATA_BITS'(fire));
      csr_write_check(REG_SAMPLE_DIVIDE, CSR_DATA_BITS'(smp));
      csr_write_check(REG_INITIAL_RELOAD, CSR_DATA_BITS'(init));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   // stimulus
   initial begin
      timer_row_t   row;
      logic [1:0]   cur_phase;
      logic         up_hold;
      logic         dn_hold;
      button_beat_t beat;
      logic [3:0]   rmin;
      logic [3:0]   rmax;
      logic [15:0]  scale;
      logic [15:0]  init;
      logic [2:0]   fire;
      logic [2:0]   smp;
      cur_phase = 2'd0;
      up_hold = 1'b0;
      dn_hold = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = TIMER_ROWS[r];
         if (row.phase != cur_phase) begin
            drain_relays(1'b1);
            if (row.phase == 2'd1)
               program_timer(4'd1, 4'd15, 16'd6, 3'd1, 3'd1, 16'd65533);
            else
               program_timer(4'd0, 4'd2, 16'd0, 3'd0, 3'd1, 16'hFFFF);
            cur_phase = row.phase;
         end
         pin_q.push_back({row.pinned, row.want});
         send_beat(row.beat);
      end

      // random phases, each under its own settings
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_relays(1'b1);
         rmin = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
         rmax = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(8, 15));
         scale = 16'($urandom_range(1, 90));
         fire = 3'($urandom_range(0, 7));
         smp = 3'($urandom_range(0, 7));
         init = 16'(17'h10000 - $urandom_range(1, 12));
         if (ph == 2)
            program_timer(4'd15, 4'd15, 16'hFFFF, 3'd7, 3'd7, 16'd0);
         else if (ph == 4)
            program_timer(4'd1, 4'd15, scale, fire, 3'd1, init);
         else
            program_timer(rmin, rmax, scale, fire, smp, init);
         // one phase runs flat out on both sides
         gaps_on = (ph != 3);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if (ph == 1 && n == BEATS_PER_PHASE / 2)
               drain_relays(1'b0);
            // buttons are held for stretches, with some bounce
            if ($urandom_range(0, 99) < 8)
               up_hold = ~up_hold;
            if ($urandom_range(0, 99) < 8)
               dn_hold = ~dn_hold;
            if ($urandom_range(0, 9) == 0) begin
               beat = 4'($urandom);
            end else begin
               beat.tick = ($urandom_range(0, 99) < 75);
               beat.strobe = ($urandom_range(0, 99) < 60);
               beat.up_n = ~up_hold ^ ($urandom_range(0, 19) == 0);
               beat.down_n = ~dn_hold ^ ($urandom_range(0, 19) == 0);
            end
            send_beat(beat);
         end
      end

      drain_relays(1'b1);
      if (pending_relays.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_relays.size()));
      $display("covered %0d request beats, %0d result beats, %0d register settings",
               beats_taken, results_seen, settings_done);
      $display("saw %0d relay firings and %0d predicted rate steps, %0d errors",
               fires_seen, rate_steps, err_count);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
design/sat_pkg.sv
design/sat_divider.sv
design/solenoid_alternator_timer_top.sv
dv/tb_solenoid_alternator_timer_top.sv
